// ===== rtl/b64enc_pkg.sv =====
// Shared types, character constants and the base64 alphabet for the stream encoder.
package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharEq    = 8'h3d;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharD     = 8'h44;

  // One classified group: four sextets, how many carry data (2 to 4),
  // stream-end flag and the escape mode sampled with the closing byte.
  typedef struct packed {
    logic [3:0][5:0] sext;
    logic [2:0]      used;
    logic            last;
    logic            esc;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] b64_char(logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + w;
    end else if (s < 6'd52) begin
      return 8'h47 + w;
    end else if (s < 6'd62) begin
      return w - 8'd4;
    end else if (s == 6'd62) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
// Input side: holds pending bytes and forms one group entry per closed group.
module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  logic                url_escape_i,
  input  b64enc_pkg::q_stat_t q_stat_i,
  output logic                push_o,
  output b64enc_pkg::grp_t    grp_o
);
  import b64enc_pkg::*;

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic [7:0]  b0, b1, b2;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    b0 = held_q[15:8];
    b1 = held_q[7:0];
    b2 = data_byte_i;
    grp_o.used = 3'd4;
    if (cnt_q == 2'd0) begin
      b0 = data_byte_i;
      b1 = 8'h00;
      b2 = 8'h00;
      grp_o.used = 3'd2;
    end else if (cnt_q == 2'd1) begin
      b0 = held_q[7:0];
      b1 = data_byte_i;
      b2 = 8'h00;
      grp_o.used = 3'd3;
    end
    grp_o.sext[0] = b0[7:2];
    grp_o.sext[1] = {b0[1:0], b1[7:4]};
    grp_o.sext[2] = {b1[3:0], b2[7:6]};
    grp_o.sext[3] = b2[5:0];
    grp_o.last    = final_byte_i;
    grp_o.esc     = url_escape_i;
  end

  assign push_o = accept && (cnt_q[1] || final_byte_i);

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (cnt_q[1] || final_byte_i) begin
        held_d = 16'h0000;
        cnt_d  = 2'd0;
      end else begin
        held_d = {held_q[7:0], data_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 16'h0000;
      cnt_q  <= 2'd0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/b64enc_queue.sv =====
// Short group queue between the input side and the character emitter.
module b64enc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64enc_pkg::grp_t    grp_i,
  input  logic                pop_i,
  output b64enc_pkg::grp_t    head_o,
  output b64enc_pkg::q_stat_t stat_o
);
  import b64enc_pkg::*;

  grp_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("queue pop while empty");
  a_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + QueueCntW'($past(push_i)) - QueueCntW'($past(pop_i)))
    else $error("queue count mismatch");

endmodule

// ===== rtl/b64enc_back.sv =====
// Output side: walks the head group one character per cycle unless stalled, with padding and escapes.
module b64enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64enc_pkg::grp_t    head_i,
  input  b64enc_pkg::q_stat_t q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                end_of_text_o
);
  import b64enc_pkg::*;

  logic [1:0] k_q, k_d;
  logic [1:0] sub_q, sub_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       eot_q, eot_d;
  logic       load, is_pad, is_esc, char_done, grp_done;
  logic [7:0] base;

  assign load = !q_stat_i.empty && (!vld_q || !out_stall_i);

  always_comb begin
    is_pad    = ({1'b0, k_q} >= head_i.used);
    base      = is_pad ? CharEq : b64_char(head_i.sext[k_q]);
    is_esc    = head_i.esc && (base inside {CharPlus, CharSlash, CharEq});
    char_done = !is_esc || (sub_q == 2'd2);
    grp_done  = char_done && (k_q == 2'd3);

    char_d = base;
    if (is_esc) begin
      case (sub_q)
        2'd0:    char_d = CharPct;
        2'd1:    char_d = (base == CharEq) ? CharThree : CharTwo;
        default: char_d = (base == CharPlus) ? CharB : ((base == CharSlash) ? CharF : CharD);
      endcase
    end
    eot_d = head_i.last && grp_done;

    k_d   = k_q;
    sub_d = sub_q;
    vld_d = vld_q && out_stall_i;
    if (load) begin
      vld_d = 1'b1;
      if (char_done) begin
        sub_d = 2'd0;
        k_d   = k_q + 2'd1;
      end else begin
        sub_d = sub_q + 2'd1;
      end
    end
  end

  assign pop_o = load && grp_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= 2'd0;
      sub_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      k_q   <= k_d;
      sub_q <= sub_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      eot_q  <= eot_d;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_char_o    = char_q;
  assign end_of_text_o = eot_q;

endmodule

// ===== rtl/base64_stream_encoder_core.sv =====
// Top level of the base64 stream encoder with percent-escape option.
//
// Input channel: one byte per word (data_byte_i, final_byte_i on the last
// byte of a stream), accepted when in_valid_i is high and in_stall_o low.
// Output channel: one ASCII character per word (out_char_o, end_of_text_o on
// the last character of a stream), taken when out_valid_o is high and
// out_stall_i low. url_escape_we_i writes url_escape_i; the escape mode is
// sampled with the byte that closes each group.
// Bytes are accepted one per cycle while the two-entry group queue has room.
// The emitter sends one character per cycle while out_stall_i is low, so a
// group of three bytes becomes four characters, up to twelve with escapes; a
// lone final byte becomes four, up to ten with escapes. A closing byte's
// group is registered in the queue, then its first character in the output
// register. Reset clears pending bytes, the queue and the output valid flag;
// escape is off. A stalled receiver holds the current character; the queue
// then fills and in_stall_o rises.
module base64_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_escape_we_i,
  input  logic       url_escape_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       end_of_text_o
);
  import b64enc_pkg::*;

  logic    esc_q;
  logic    push, pop;
  grp_t    grp_in, grp_head;
  q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else if (url_escape_we_i) begin
      esc_q <= url_escape_i;
    end
  end

  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .url_escape_i (esc_q),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .grp_o        (grp_in)
  );

  b64enc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .grp_i  (grp_in),
    .pop_i  (pop),
    .head_o (grp_head),
    .stat_o (q_stat)
  );

  b64enc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (grp_head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule

// ===== tb/sv/b64enc_stream_checker.sv =====
// Checker for the base64 stream encoder: watches both channels, predicts and compares characters.
`timescale 1ns / 100ps

module b64enc_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_escape_we_i,
  input  logic       url_escape_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic       end_of_text_i,
  output int         err_cnt_o,
  output int         pend_cnt_o,
  output int         char_cnt_o
);
  import b64enc_pkg::*;

  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [15:0] held_q;
  logic [1:0]  held_n;
  logic        esc_q;
  logic [7:0]  grp_chars[$];
  logic [7:0]  exp_char_q[$];
  logic        exp_eot_q[$];
  logic [7:0]  want_char;
  logic        want_eot;
  int          n_errs;
  int          n_chars;

  task automatic report(input string msg);
    if (n_errs < 40) $display("%0t ns  check: %s", $time, msg);
    n_errs++;
  endtask

  // one output character, percent-escaped when the mode asks for it
  task automatic emit(input logic [7:0] c);
    if (esc_q && (c inside {CharPlus, CharSlash, CharEq})) begin
      grp_chars.push_back(CharPct);
      case (c)
        CharPlus: begin
          grp_chars.push_back(CharTwo);
          grp_chars.push_back(CharB);
        end
        CharSlash: begin
          grp_chars.push_back(CharTwo);
          grp_chars.push_back(CharF);
        end
        default: begin
          grp_chars.push_back(CharThree);
          grp_chars.push_back(CharD);
        end
      endcase
    end else begin
      grp_chars.push_back(c);
    end
  endtask

  task automatic emit_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int used);
    logic [23:0] bits;
    int          idx;
    int          k;
    bits = {b0, b1, b2};
    for (k = 0; k < 4; k++) begin
      idx = int'(bits[23 - 6 * k -: 6]);
      if (k < used) emit(Alphabet[8 * (63 - idx) +: 8]);
      else emit(CharEq);
    end
  endtask

  task automatic encode_byte(input logic [7:0] d, input logic is_last);
    logic [1:0] n;
    int         i;
    n = (held_n == 2'd3) ? 2'd2 : held_n;
    grp_chars.delete();
    if (n == 2'd2) begin
      emit_group(held_q[15:8], held_q[7:0], d, 4);
      held_q = '0;
      held_n = '0;
    end else if (is_last) begin
      if (n == 2'd0) emit_group(d, 8'h00, 8'h00, 2);
      else emit_group(held_q[7:0], d, 8'h00, 3);
    end else begin
      held_q = {held_q[7:0], d};
      held_n = n + 2'd1;
    end
    if (is_last) begin
      held_q = '0;
      held_n = '0;
    end
    for (i = 0; i < grp_chars.size(); i++) begin
      exp_char_q.push_back(grp_chars[i]);
      exp_eot_q.push_back(is_last && (i == grp_chars.size() - 1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q = '0;
      held_n = '0;
      esc_q = 1'b0;
      exp_char_q.delete();
      exp_eot_q.delete();
      n_errs = 0;
      n_chars = 0;
      err_cnt_o <= 0;
      pend_cnt_o <= 0;
      char_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        n_chars++;
        if (exp_char_q.size() == 0) begin
          report($sformatf("character 8'h%02h with none pending", out_char_i));
        end else begin
          want_char = exp_char_q.pop_front();
          want_eot = exp_eot_q.pop_front();
          if (out_char_i !== want_char)
            report($sformatf("char 8'h%02h, want 8'h%02h", out_char_i, want_char));
          if (end_of_text_i !== want_eot)
            report($sformatf("end_of_text %b, want %b on char 8'h%02h",
                             end_of_text_i, want_eot, want_char));
        end
      end
      if (in_valid_i && !in_stall_i) encode_byte(data_byte_i, final_byte_i);
      if (url_escape_we_i) esc_q = url_escape_i;
      err_cnt_o <= n_errs;
      pend_cnt_o <= exp_char_q.size();
      char_cnt_o <= n_chars;
    end
  end

endmodule

// ===== tb/sv/tb_base64_stream_encoder_core.sv =====
// Testbench top for the base64 stream encoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_base64_stream_encoder_core;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       url_escape_we_i = 1'b0;
  logic       url_escape_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic       end_of_text_o;

  logic       calm = 1'b0;
  logic       esc_now = 1'b0;
  int         err_cnt;
  int         pend_cnt;
  int         char_cnt;
  int         bytes_sent = 0;
  int         streams_sent = 0;
  int         esc_writes = 0;

  base64_stream_encoder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .url_escape_we_i(url_escape_we_i),
    .url_escape_i   (url_escape_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .end_of_text_o  (end_of_text_o)
  );

  b64enc_stream_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .url_escape_we_i(url_escape_we_i),
    .url_escape_i   (url_escape_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_i     (out_char_o),
    .end_of_text_i  (end_of_text_o),
    .err_cnt_o      (err_cnt),
    .pend_cnt_o     (pend_cnt),
    .char_cnt_o     (char_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 26);
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'hfb;
      3: return 8'hef;
      4: return 8'hbe;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic is_last);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    final_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_stream(input int len);
    int i;
    for (i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
    streams_sent++;
  endtask

  // hold input until every predicted character is out, then write the mode
  task automatic write_escape(input logic v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pend_cnt == 0);
    repeat (4) @(posedge clk_i);
    url_escape_we_i <= 1'b1;
    url_escape_i <= v;
    @(posedge clk_i);
    url_escape_we_i <= 1'b0;
    esc_now = v;
    esc_writes++;
  endtask

  initial begin
    int len;
    int phase;
    int phase_end;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain alphabet: one and two byte tails, full groups, group plus tail
    write_escape(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b0);
    send_byte(8'h21, 1'b1);

    // escaped plus, slash and padding
    write_escape(1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hff, 1'b1);

    // mode flips while two bytes are held
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b0);
    write_escape(1'b0);
    send_byte(8'hff, 1'b1);
    streams_sent += 9;

    phase = 0;
    phase_end = bytes_sent + 40;
    while (bytes_sent < 220) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
      send_stream(len);
      if (bytes_sent >= phase_end) begin
        phase++;
        phase_end = bytes_sent + 40;
        write_escape($urandom_range(3) == 0 ? esc_now : !esc_now);
        calm <= (phase == 2);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pend_cnt == 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d bytes in %0d streams, %0d characters out, %0d escape-mode writes",
             bytes_sent, streams_sent, char_cnt, esc_writes);
    $display("streams ran with and without percent escaping, under random stalls");
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== base64_stream_encoder_core.f =====
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder_core.sv
tb/sv/b64enc_stream_checker.sv
tb/sv/tb_base64_stream_encoder_core.sv
